// ===== hdl/lir_pkg.sv =====
`default_nettype none

package lir_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int RATE_W     = 24;
    localparam int POS_W      = RATE_W + 1;
    localparam int RAMP_W     = 17;
    localparam int PHASE_W    = 16;
    localparam int MAX_RUN    = 64;
    localparam int CNT_W      = $clog2(MAX_RUN + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;
    localparam int RSUM_W     = RATE_W + 2;

    // Rate limits, 8.16 fixed point
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1) << (FRAC_W - 6);
    localparam logic [RATE_W-1:0] RATE_MAX   = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1) << FRAC_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_RATE  = 2'd0,
        CFG_RATE_RAMP   = 2'd1,
        CFG_START_PHASE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0]        start_rate;
        logic signed [RAMP_W-1:0] rate_ramp;
        logic [PHASE_W-1:0]       start_phase;
    } cfg_t;

    // Request held in the queue between front and engine
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } q_item_t;

    // One interpolation job handed to the datapath
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] cur;
        logic [FRAC_W-1:0]          frac;
        logic                       last;
    } lerp_req_t;

endpackage

`default_nettype wire

// ===== hdl/lir_front.sv =====
`default_nettype none

module lir_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                                first,
    output logic                                     q_valid,
    input  wire logic                                q_pop,
    output lir_pkg::q_item_t                         q_item
);

    lir_pkg::q_item_t fifo_mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             primed_reg;
    logic             primed_next;
    logic             push;
    logic             pop;
    lir_pkg::q_item_t push_item;

    // Classify: the first request after reset counts as a restart
    always_comb
    begin
        push              = in_valid && !in_stall;
        pop               = q_pop && q_valid;
        push_item.sample  = in_sample;
        push_item.restart = first || !primed_reg;
        primed_next       = primed_reg || push;
        wr_ptr_next       = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next       = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next        = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            primed_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            primed_reg <= primed_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lir_engine.sv =====
`default_nettype none

module lir_engine
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lir_pkg::cfg_t     cfg,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire lir_pkg::q_item_t  q_item,
    output logic                   req_valid,
    input  wire logic              req_ready,
    output lir_pkg::lerp_req_t     req
);

    logic signed [lir_pkg::SAMPLE_W-1:0] prev_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] prev_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_next;
    logic [lir_pkg::POS_W-1:0]           pos_reg;
    logic [lir_pkg::POS_W-1:0]           pos_next;
    logic [lir_pkg::RATE_W-1:0]          rate_reg;
    logic [lir_pkg::RATE_W-1:0]          rate_next;
    logic [lir_pkg::CNT_W-1:0]           n_reg;
    logic [lir_pkg::CNT_W-1:0]           n_next;
    logic                                busy_reg;
    logic                                busy_next;

    logic                                in_range;
    logic [lir_pkg::POS_W-1:0]           pos_sum;
    logic signed [lir_pkg::RSUM_W-1:0]   rate_sum;
    logic [lir_pkg::RATE_W-1:0]          rate_ramped;
    logic [lir_pkg::RATE_W-1:0]          rate_start;
    logic                                issue;

    // Position step and rate ramp with saturation
    always_comb
    begin
        in_range = (pos_reg[lir_pkg::POS_W-1:lir_pkg::FRAC_W] == '0)
                   && (n_reg < lir_pkg::CNT_W'(lir_pkg::MAX_RUN));
        pos_sum  = pos_reg + {1'b0, rate_reg};
        rate_sum = $signed({2'b00, rate_reg})
                   + lir_pkg::RSUM_W'(cfg.rate_ramp);
        if (rate_sum < $signed({2'b00, lir_pkg::RATE_MIN}))
        begin
            rate_ramped = lir_pkg::RATE_MIN;
        end
        else if (rate_sum > $signed({2'b00, lir_pkg::RATE_MAX}))
        begin
            rate_ramped = lir_pkg::RATE_MAX;
        end
        else
        begin
            rate_ramped = rate_sum[lir_pkg::RATE_W-1:0];
        end
        rate_start = (cfg.start_rate < lir_pkg::RATE_MIN) ? lir_pkg::RATE_MIN
                                                          : cfg.start_rate;
    end

    // Sequence: pop a request, emit its run, then close the interval (a restart only loads state)
    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        pos_next  = pos_reg;
        rate_next = rate_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        q_pop     = 1'b0;
        issue     = 1'b0;

        if (!busy_reg)
        begin
            q_pop = q_valid;
            if (q_valid)
            begin
                if (q_item.restart)
                begin
                    prev_next = q_item.sample;
                    pos_next  = lir_pkg::POS_W'(cfg.start_phase);
                    rate_next = rate_start;
                end
                else
                begin
                    cur_next  = q_item.sample;
                    n_next    = '0;
                    busy_next = 1'b1;
                end
            end
        end
        else if (in_range)
        begin
            issue = req_ready;
            if (req_ready)
            begin
                pos_next  = pos_sum;
                rate_next = rate_ramped;
                n_next    = n_reg + lir_pkg::CNT_W'(1);
            end
        end
        else
        begin
            // Drop one whole sample, or clear after a capped run
            if (pos_reg[lir_pkg::POS_W-1:lir_pkg::FRAC_W] != '0)
            begin
                pos_next = pos_reg - (lir_pkg::POS_W'(1) << lir_pkg::FRAC_W);
            end
            else
            begin
                pos_next = '0;
            end
            prev_next = cur_reg;
            busy_next = 1'b0;
        end
    end

    assign req_valid = issue;
    assign req.prev  = prev_reg;
    assign req.cur   = cur_reg;
    assign req.frac  = pos_reg[lir_pkg::FRAC_W-1:0];
    assign req.last  = (pos_sum[lir_pkg::POS_W-1:lir_pkg::FRAC_W] != '0)
                       || (n_reg == lir_pkg::CNT_W'(lir_pkg::MAX_RUN - 1));

    // Hold resampler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            cur_reg  <= '0;
            pos_reg  <= '0;
            rate_reg <= lir_pkg::RATE_RESET;
            n_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            cur_reg  <= cur_next;
            pos_reg  <= pos_next;
            rate_reg <= rate_next;
            n_reg    <= n_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lir_lerp.sv =====
`default_nettype none

module lir_lerp
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire lir_pkg::lerp_req_t      req,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
    output logic                         last
);

    logic signed [lir_pkg::PROD_W-1:0]   prod_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] base_reg;
    logic                                s1_last_reg;
    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                out_last_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    logic signed [lir_pkg::DIFF_W-1:0]   diff;
    logic signed [lir_pkg::PROD_W-1:0]   prod;
    logic signed [lir_pkg::PROD_W-1:0]   acc;
    logic                                adv_out;
    logic                                load_s1;

    // Handshake between the two stages
    always_comb
    begin
        adv_out        = !out_valid_reg || !out_stall;
        req_ready      = !s1_valid_reg || adv_out;
        load_s1        = req_valid && req_ready;
        s1_valid_next  = load_s1 ? 1'b1 : (adv_out ? 1'b0 : s1_valid_reg);
        out_valid_next = adv_out ? s1_valid_reg : out_valid_reg;
    end

    // Stage one: slope times fraction
    always_comb
    begin
        diff = lir_pkg::DIFF_W'(req.cur) - lir_pkg::DIFF_W'(req.prev);
        prod = lir_pkg::PROD_W'(diff) * $signed({1'b0, req.frac});
    end

    // Stage two: add base and round half up
    always_comb
    begin
        acc = (lir_pkg::PROD_W'(base_reg) <<< lir_pkg::FRAC_W) + prod_reg
              + (lir_pkg::PROD_W'(1) <<< (lir_pkg::FRAC_W - 1));
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            prod_reg    <= prod;
            base_reg    <= req.prev;
            s1_last_reg <= req.last;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_sample_reg <= acc[lir_pkg::FRAC_W+lir_pkg::SAMPLE_W-1:lir_pkg::FRAC_W];
            out_last_reg   <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/linear_interp_resampler.sv =====
// Flow: the engine pops a request from the queue when idle; its results pass the
// stage-one register and the output register, one result per cycle while not stalled.
// Sequence: a request with n results is popped, issued n times through the shared
// multiplier, then its interval is closed before the next pop; a restart only loads state.
// Reset: asynchronous, active low; clears the queue, pipeline and state, loads defaults.
`default_nettype none

module linear_interp_resampler
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]         wr_index,
    input  wire logic [lir_pkg::CFG_DATA_W-1:0]        wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic                                  first,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [lir_pkg::SAMPLE_W-1:0]        out_sample,
    output logic                                       last
);

    lir_pkg::cfg_t      cfg_reg;
    lir_pkg::cfg_t      cfg_next;
    logic               q_valid;
    logic               q_pop;
    lir_pkg::q_item_t   q_item;
    logic               req_valid;
    logic               req_ready;
    lir_pkg::lerp_req_t req;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (lir_pkg::cfg_idx_t'(wr_index))
                lir_pkg::CFG_START_RATE:
                begin
                    cfg_next.start_rate = wr_data[lir_pkg::RATE_W-1:0];
                end
                lir_pkg::CFG_RATE_RAMP:
                begin
                    cfg_next.rate_ramp = $signed(wr_data[lir_pkg::RAMP_W-1:0]);
                end
                lir_pkg::CFG_START_PHASE:
                begin
                    cfg_next.start_phase = wr_data[lir_pkg::PHASE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_rate  <= lir_pkg::RATE_RESET;
            cfg_reg.rate_ramp   <= '0;
            cfg_reg.start_phase <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lir_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_sample (in_sample),
        .first     (first),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    lir_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    lir_lerp u_lerp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .last       (last)
    );

endmodule

`default_nettype wire
